FILE: hw/rtl/assert_macros.svh
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

FILE: hw/rtl/slfc_pkg.sv
`timescale 1ns / 1ps
package slfc_pkg;

  typedef enum logic [3:0] {
    MODE_START  = 4'd0,
    MODE_PREFIX = 4'd1,
    MODE_FIN    = 4'd2,
    MODE_PROG   = 4'd3,
    MODE_INT    = 4'd4,
    MODE_FS     = 4'd5,
    MODE_ERR    = 4'd6,
    MODE_MOCK   = 4'd7,
    MODE_VER    = 4'd8
  } mode_e;

  typedef enum logic [3:0] {
    KIND_PROGRESS  = 4'd0,
    KIND_COUNTDOWN = 4'd1,
    KIND_FALSE_ST  = 4'd2,
    KIND_FINISH    = 4'd3,
    KIND_LENGTH    = 4'd4,
    KIND_MOCK      = 4'd5,
    KIND_VERSION   = 4'd6,
    KIND_ERROR     = 4'd7,
    KIND_START     = 4'd8,
    KIND_STOP      = 4'd9,
    KIND_UNKNOWN   = 4'd10
  } kind_e;

  localparam logic [31:0] I32MagMax = 32'd2147483647;
  localparam logic [3:0]  MaxDigits = 4'd10;

  typedef struct packed {
    logic [3:0]  frame_kind;
    logic [31:0] small_value;
    logic [31:0] finish_time_ms;
    logic [31:0] tick_a;
    logic [31:0] tick_b;
    logic [31:0] tick_c;
    logic [31:0] tick_d;
    logic [31:0] elapsed_time_ms;
    logic [31:0] length_value;
    logic        mock_enabled;
  } frame_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       line_end;
  } item_t;

  // Expected prefix byte at a position for a given first byte; 0 if none.
  function automatic logic [7:0] prefix_char(input logic [7:0] fb, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    if (fb >= "0" && fb <= "3") begin
      case (pos)
        3'd1: c = "F";
        3'd2: c = ":";
        default: c = 8'h00;
      endcase
    end else begin
      case (fb)
        "R", "L", "M", "V": c = (pos == 3'd1) ? ":" : 8'h00;
        "C": c = (pos == 3'd1) ? "D" : (pos == 3'd2) ? ":" : 8'h00;
        "F": c = (pos == 3'd1) ? "S" : (pos == 3'd2) ? ":" : 8'h00;
        "E": begin
          case (pos)
            3'd1: c = "R";
            3'd2: c = "R";
            3'd3: c = "O";
            3'd4: c = "R";
            3'd5: c = ":";
            default: c = 8'h00;
          endcase
        end
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

  function automatic logic [2:0] prefix_len(input logic [7:0] fb);
    logic [2:0] l;
    l = 3'd0;
    if (fb >= "0" && fb <= "3") l = 3'd3;
    else begin
      case (fb)
        "R", "L", "M", "V": l = 3'd2;
        "C", "F": l = 3'd3;
        "E": l = 3'd6;
        default: l = 3'd0;
      endcase
    end
    return l;
  endfunction

  function automatic mode_e body_mode(input logic [7:0] fb);
    mode_e m;
    m = MODE_START;
    if (fb >= "0" && fb <= "3") m = MODE_FIN;
    else begin
      case (fb)
        "R": m = MODE_PROG;
        "C", "L": m = MODE_INT;
        "F": m = MODE_FS;
        "E": m = MODE_ERR;
        "M": m = MODE_MOCK;
        "V": m = MODE_VER;
        default: m = MODE_START;
      endcase
    end
    return m;
  endfunction

endpackage

FILE: hw/rtl/slfc_stream_if.sv
`timescale 1ns / 1ps
interface slfc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/slfc_parser.sv
`timescale 1ns / 1ps
// Line parser: consumes one registered byte per cycle while en_i is high and builds the frame on line end.
module slfc_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  slfc_pkg::item_t       item_i,
  output slfc_pkg::frame_t      frame_o
);

  slfc_pkg::mode_e mode_q, mode_d;
  logic [2:0]  pos_q, pos_d;
  logic [7:0]  first_q, first_d;
  logic [31:0] acc_q, acc_d;
  logic [3:0]  dcnt_q, dcnt_d;
  logic        minus_q, minus_d;
  logic [2:0]  fidx_q, fidx_d;
  logic        inv_q, inv_d;
  logic [31:0] prog_q [4];
  logic        prog_we;

  logic [7:0]  b;
  logic        byte_dec;
  logic [35:0] acc_x10;
  logic        dig_ok;
  logic [31:0] dig_acc;
  logic [7:0]  exp_c;

  assign b = item_i.line_byte;
  assign byte_dec = (b >= "0") && (b <= "9");
  // Times ten as shift-add, kept wide to catch overflow.
  assign acc_x10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, b[3:0]};
  assign dig_ok = byte_dec && (dcnt_q < slfc_pkg::MaxDigits) && (acc_x10[35:32] == 4'd0);
  assign dig_acc = acc_x10[31:0];
  assign exp_c = slfc_pkg::prefix_char(first_q, pos_q);

  // Next-state logic for one byte or a line end.
  always_comb begin
    mode_d = mode_q; pos_d = pos_q; first_d = first_q; acc_d = acc_q;
    dcnt_d = dcnt_q; minus_d = minus_q; fidx_d = fidx_q; inv_d = inv_q;
    prog_we = 1'b0;
    if (item_i.line_end) begin
      mode_d = slfc_pkg::MODE_START; pos_d = '0; first_d = '0; acc_d = '0;
      dcnt_d = '0; minus_d = 1'b0; fidx_d = '0; inv_d = 1'b0;
    end else if (!inv_q) begin
      unique case (mode_q)
        slfc_pkg::MODE_START: begin
          first_d = b; pos_d = 3'd1; mode_d = slfc_pkg::MODE_PREFIX;
          if (slfc_pkg::prefix_len(b) == 3'd0 && b != "G" && b != "S") inv_d = 1'b1;
        end
        slfc_pkg::MODE_PREFIX: begin
          if (slfc_pkg::prefix_len(first_q) == 3'd0 ||
              pos_q >= slfc_pkg::prefix_len(first_q) || b != exp_c) begin
            inv_d = 1'b1;
          end else begin
            pos_d = pos_q + 3'd1;
            if (pos_q + 3'd1 == slfc_pkg::prefix_len(first_q)) begin
              mode_d = slfc_pkg::body_mode(first_q);
              pos_d = '0; acc_d = '0; dcnt_d = '0; minus_d = 1'b0; fidx_d = '0;
            end
          end
        end
        slfc_pkg::MODE_FIN, slfc_pkg::MODE_FS: begin
          if (dig_ok) begin acc_d = dig_acc; dcnt_d = dcnt_q + 4'd1; end
          else inv_d = 1'b1;
        end
        slfc_pkg::MODE_PROG: begin
          if (b == ",") begin
            if (dcnt_q == 4'd0 || fidx_q >= 3'd4) inv_d = 1'b1;
            else begin
              prog_we = 1'b1; fidx_d = fidx_q + 3'd1; acc_d = '0; dcnt_d = '0;
            end
          end else if (dig_ok) begin
            acc_d = dig_acc; dcnt_d = dcnt_q + 4'd1;
          end else inv_d = 1'b1;
        end
        slfc_pkg::MODE_INT: begin
          if (pos_q == 3'd0 && (b == "+" || b == "-")) minus_d = (b == "-");
          else if (dig_ok) begin acc_d = dig_acc; dcnt_d = dcnt_q + 4'd1; end
          else inv_d = 1'b1;
          pos_d = 3'd1;
        end
        slfc_pkg::MODE_MOCK: begin
          if (pos_q == 3'd0 && b == "O") pos_d = 3'd1;
          else if (pos_q == 3'd1 && (b == "N" || b == "F")) begin
            fidx_d = (b == "N") ? 3'd1 : 3'd2; pos_d = 3'd2;
          end else if (pos_q == 3'd2 && fidx_q == 3'd2 && b == "F") pos_d = 3'd3;
          else inv_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Line state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= slfc_pkg::MODE_START; pos_q <= '0; first_q <= '0; acc_q <= '0;
      dcnt_q <= '0; minus_q <= 1'b0; fidx_q <= '0; inv_q <= 1'b0;
    end else if (en_i) begin
      mode_q <= mode_d; pos_q <= pos_d; first_q <= first_d; acc_q <= acc_d;
      dcnt_q <= dcnt_d; minus_q <= minus_d; fidx_q <= fidx_d; inv_q <= inv_d;
    end
  end

  // Progress field store, no reset.
  always_ff @(posedge clk_i) begin
    if (en_i && prog_we) prog_q[fidx_q[1:0]] <= acc_q;
  end

  // Frame built from the state at line end.
  always_comb begin
    logic [31:0] sv;
    sv = minus_q ? (32'd0 - acc_q) : acc_q;
    frame_o = '0;
    frame_o.frame_kind = slfc_pkg::KIND_UNKNOWN;
    if (!inv_q) begin
      case (mode_q)
        slfc_pkg::MODE_PREFIX: begin
          if (pos_q == 3'd1 && first_q == "G") frame_o.frame_kind = slfc_pkg::KIND_START;
          else if (pos_q == 3'd1 && first_q == "S") frame_o.frame_kind = slfc_pkg::KIND_STOP;
        end
        slfc_pkg::MODE_FIN: if (dcnt_q != 4'd0) begin
          frame_o.frame_kind = slfc_pkg::KIND_FINISH;
          frame_o.small_value = {30'd0, first_q[1:0]};
          frame_o.finish_time_ms = acc_q;
        end
        slfc_pkg::MODE_PROG: if (fidx_q == 3'd4 && dcnt_q != 4'd0) begin
          frame_o.frame_kind = slfc_pkg::KIND_PROGRESS;
          frame_o.tick_a = prog_q[0]; frame_o.tick_b = prog_q[1];
          frame_o.tick_c = prog_q[2]; frame_o.tick_d = prog_q[3];
          frame_o.elapsed_time_ms = acc_q;
        end
        slfc_pkg::MODE_INT: if (dcnt_q != 4'd0 && acc_q <= slfc_pkg::I32MagMax) begin
          if (first_q == "C") begin
            frame_o.frame_kind = slfc_pkg::KIND_COUNTDOWN; frame_o.small_value = sv;
          end else begin
            frame_o.frame_kind = slfc_pkg::KIND_LENGTH; frame_o.length_value = sv;
          end
        end
        slfc_pkg::MODE_FS: if (dcnt_q != 4'd0 && acc_q <= 32'd3) begin
          frame_o.frame_kind = slfc_pkg::KIND_FALSE_ST; frame_o.small_value = acc_q;
        end
        slfc_pkg::MODE_ERR: frame_o.frame_kind = slfc_pkg::KIND_ERROR;
        slfc_pkg::MODE_VER: frame_o.frame_kind = slfc_pkg::KIND_VERSION;
        slfc_pkg::MODE_MOCK: begin
          if (pos_q == 3'd2 && fidx_q == 3'd1) begin
            frame_o.frame_kind = slfc_pkg::KIND_MOCK; frame_o.mock_enabled = 1'b1;
          end else if (pos_q == 3'd3 && fidx_q == 3'd2) begin
            frame_o.frame_kind = slfc_pkg::KIND_MOCK;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/serial_line_frame_classifier_top.sv
`timescale 1ns / 1ps
// Serial line frame classifier: one byte or line end taken per cycle unless the input is held.
// A line-end transfer is first registered in the input register and is loaded into the result register
// once that register is free; the result register's frame drives the output.
// Throughput: one input transfer every cycle while the output is taken.
// A line end in the input register facing a full result register holds the input.
// Reset (rst_ni low, asynchronous) clears the parser line state and both valid flags; the progress store is not reset.
`include "assert_macros.svh"
module serial_line_frame_classifier_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  slfc_stream_if.sink   in_i,
  slfc_stream_if.source out_o
);

  logic             in_vld_q;
  slfc_pkg::item_t  in_q;
  logic             out_vld_q;
  slfc_pkg::frame_t out_q;
  slfc_pkg::frame_t frame;
  logic             stage_go;
  logic             out_free;

  // The input stage advances unless it holds a line end facing a full output.
  assign out_free = !out_vld_q || out_o.ready;
  assign stage_go = !(in_vld_q && in_q.line_end && !out_free);
  assign in_i.ready = stage_go;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_vld_q <= 1'b0;
    else if (stage_go) in_vld_q <= in_i.valid;
  end
  always_ff @(posedge clk_i) begin
    if (stage_go && in_i.valid) in_q <= in_i.payload;
  end

  slfc_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (in_vld_q && stage_go),
    .item_i (in_q),
    .frame_o(frame)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (in_vld_q && in_q.line_end && out_free) out_vld_q <= 1'b1;
    else if (out_o.ready) out_vld_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (in_vld_q && in_q.line_end && out_free) out_q <= frame;
  end

  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  `ASSERT_NEXT(a_hold_out, clk_i, rst_ni, out_vld_q && !out_o.ready, out_vld_q)
  `ASSERT_IMPLIES(a_stall_only_end, clk_i, rst_ni, !in_i.ready, in_vld_q && in_q.line_end)
  `ASSERT_IMPLIES(a_kind_range, clk_i, rst_ni, out_vld_q, out_q.frame_kind <= slfc_pkg::KIND_UNKNOWN)

endmodule
